@@ rtl/mm_pkg.sv @@
// ----------------------------------------------------------------------------
// mm_pkg: shared types and constants of the matrix multiply block
// Field widths, command and register codes, queue entry and pipeline tags.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DIM_W  = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 2 * DATA_W;
  // Up to eight products are summed, so three guard bits keep the sum exact.
  localparam int unsigned ACC_W  = PROD_W + IDX_W;
  localparam int unsigned FRAC_W = 16;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [1:0] CFG_ROWS_A = 2'd0;
  localparam logic [1:0] CFG_COLS_A = 2'd1;
  localparam logic [1:0] CFG_ROWS_B = 2'd2;
  localparam logic [1:0] CFG_COLS_B = 2'd3;

  localparam logic [DIM_W-1:0] ROWS_A_RESET = 4'd2;
  localparam logic [DIM_W-1:0] COLS_A_RESET = 4'd3;
  localparam logic [DIM_W-1:0] ROWS_B_RESET = 4'd3;
  localparam logic [DIM_W-1:0] COLS_B_RESET = 4'd2;

  // Half an output LSB, added before the final shift for round to nearest.
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_COMPUTE,
    OP_MISMATCH
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
  } q_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] rows_last;
    logic [IDX_W-1:0] inner_last;
    logic [IDX_W-1:0] cols_last;
    logic             mismatch;
  } dims_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_term;
    logic             last_entry;
    logic             mismatch;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } term_t;

endpackage

@@ rtl/mm_in_if.sv @@
// ----------------------------------------------------------------------------
// mm_in_if: command channel of the matrix multiply block
// Valid/ready channel carrying one load or compute command.
// ----------------------------------------------------------------------------
interface mm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  row_index;
  logic [2:0]  col_index;
  logic [31:0] element_value;

  modport source (output valid, command, row_index, col_index, element_value,
                  input ready);
  modport sink (input valid, command, row_index, col_index, element_value,
                output ready);
endinterface

@@ rtl/mm_out_if.sv @@
// ----------------------------------------------------------------------------
// mm_out_if: result channel of the matrix multiply block
// Valid/ready channel carrying one product entry or a status result.
// ----------------------------------------------------------------------------
interface mm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_row;
  logic [2:0]  out_col;
  logic [31:0] product_value;
  logic        status;
  logic        last;

  modport source (output valid, out_row, out_col, product_value, status, last,
                  input ready);
  modport sink (input valid, out_row, out_col, product_value, status, last,
                output ready);
endinterface

@@ rtl/mm_front.sv @@
// ----------------------------------------------------------------------------
// mm_front: command decode
// Accepts commands, drops unused ones and out-of-range loads, resolves the
// dimension check of a compute and pushes the result into the queue.
// ----------------------------------------------------------------------------
module mm_front #(
  parameter int unsigned MAX_DIM = 8
) (
  mm_in_if.sink           in_ch,
  input  mm_pkg::dims_t   dims_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output mm_pkg::q_item_t q_item_o
);
  import mm_pkg::*;

  logic in_range;
  logic keep;

  assign in_ch.ready = !q_full_i;

  always_comb begin
    in_range = (32'(in_ch.row_index) < MAX_DIM) && (32'(in_ch.col_index) < MAX_DIM);
    q_item_o.row   = in_ch.row_index;
    q_item_o.col   = in_ch.col_index;
    q_item_o.value = in_ch.element_value;
    q_item_o.op    = OP_LOAD_A;
    keep           = 1'b0;
    case (in_ch.command)
      CMD_LOAD_A: begin
        q_item_o.op = OP_LOAD_A;
        keep        = in_range;
      end
      CMD_LOAD_B: begin
        q_item_o.op = OP_LOAD_B;
        keep        = in_range;
      end
      CMD_COMPUTE: begin
        q_item_o.op = dims_i.mismatch ? OP_MISMATCH : OP_COMPUTE;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    q_push_o = in_ch.valid && !q_full_i && keep;
  end

endmodule

@@ rtl/mm_fifo.sv @@
// ----------------------------------------------------------------------------
// mm_fifo: command queue
// Short first-in first-out queue between the decode and execute sides.
// ----------------------------------------------------------------------------
module mm_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mm_pkg::q_item_t item_i,
  input  logic            pop_i,
  output mm_pkg::q_item_t head_o,
  output logic            full_o,
  output logic            empty_o
);
  import mm_pkg::*;

  q_item_t           slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QPTR_W + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ rtl/mm_back.sv @@
// ----------------------------------------------------------------------------
// mm_back: execute sequencer and matrix stores
// Writes loads into the A and B stores and walks row, column and inner
// index of a compute, reading one A and one B entry per cycle unless held.
// ----------------------------------------------------------------------------
module mm_back #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  mm_pkg::q_item_t             q_head_i,
  output logic                        q_pop_o,
  input  mm_pkg::dims_t               dims_i,
  input  logic                        hold_i,
  output mm_pkg::term_t               term_o,
  output logic [mm_pkg::DATA_W-1:0]   a_data_o,
  output logic [mm_pkg::DATA_W-1:0]   b_data_o
);
  import mm_pkg::*;

  localparam int unsigned MemDepth = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  back_state_e      state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] t_q, t_d;
  term_t            term_q, term_d;
  logic             a_we, b_we;
  logic             run_done;
  logic [AddrW-1:0] wr_addr, a_addr, b_addr;

  logic [DATA_W-1:0] mem_a [MemDepth];
  logic [DATA_W-1:0] mem_b [MemDepth];
  logic [DATA_W-1:0] a_rd_q, b_rd_q;

  assign wr_addr = AddrW'(32'(q_head_i.row) * MAX_DIM + 32'(q_head_i.col));
  assign a_addr  = AddrW'(32'(i_q) * MAX_DIM + 32'(t_q));
  assign b_addr  = AddrW'(32'(t_q) * MAX_DIM + 32'(j_q));

  assign run_done = (i_q == dims_i.rows_last) && (j_q == dims_i.cols_last) &&
                    (t_q == dims_i.inner_last);

  assign term_o   = term_q;
  assign a_data_o = a_rd_q;
  assign b_data_o = b_rd_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && !hold_i && (q_head_i.op == OP_COMPUTE)) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!hold_i && run_done) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop_o = 1'b0;
    a_we    = 1'b0;
    b_we    = 1'b0;
    term_d  = '0;
    i_d     = i_q;
    j_d     = j_q;
    t_d     = t_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && !hold_i) begin
          q_pop_o = 1'b1;
          case (q_head_i.op)
            OP_LOAD_A: a_we = 1'b1;
            OP_LOAD_B: b_we = 1'b1;
            OP_MISMATCH: begin
              // A status result rides the pipeline as a single zero term.
              term_d.valid      = 1'b1;
              term_d.first      = 1'b1;
              term_d.last_term  = 1'b1;
              term_d.last_entry = 1'b1;
              term_d.mismatch   = 1'b1;
            end
            OP_COMPUTE: begin
              i_d = '0;
              j_d = '0;
              t_d = '0;
            end
            default: ;
          endcase
        end
      end
      BK_RUN: begin
        if (!hold_i) begin
          term_d.valid      = 1'b1;
          term_d.first      = (t_q == '0);
          term_d.last_term  = (t_q == dims_i.inner_last);
          term_d.last_entry = (i_q == dims_i.rows_last) && (j_q == dims_i.cols_last);
          term_d.row        = i_q;
          term_d.col        = j_q;
          if (t_q == dims_i.inner_last) begin
            t_d = '0;
            if (j_q == dims_i.cols_last) begin
              j_d = '0;
              i_d = i_q + IDX_W'(1);
            end else begin
              j_d = j_q + IDX_W'(1);
            end
          end else begin
            t_d = t_q + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      t_q     <= '0;
      term_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      t_q     <= t_d;
      if (!hold_i) begin
        term_q <= term_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      mem_a[wr_addr] <= q_head_i.value;
    end
    if (!hold_i) begin
      a_rd_q <= mem_a[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      mem_b[wr_addr] <= q_head_i.value;
    end
    if (!hold_i) begin
      b_rd_q <= mem_b[b_addr];
    end
  end

endmodule

@@ rtl/mm_mac.sv @@
// ----------------------------------------------------------------------------
// mm_mac: multiply-accumulate and result stage
// Multiplies one A and B entry per cycle unless held, sums the exact products
// of one entry, rounds to Q16.16, saturates and holds the result for transfer.
// ----------------------------------------------------------------------------
module mm_mac (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mm_pkg::term_t             term_i,
  input  logic [mm_pkg::DATA_W-1:0] a_i,
  input  logic [mm_pkg::DATA_W-1:0] b_i,
  output logic                      hold_o,
  mm_out_if.source                  out_ch
);
  import mm_pkg::*;

  localparam int unsigned TopLo = FRAC_W + DATA_W - 1;

  logic signed [DATA_W-1:0] a_s, b_s;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]         rnd;
  logic [ACC_W-1:TopLo]     rnd_top;
  logic [DATA_W-1:0]        sat;
  term_t                    tag2_q, tag3_q, tag3_d;

  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic [DATA_W-1:0]        out_value_q;
  logic                     out_status_q, out_last_q;

  assign hold_o = out_valid_q && !out_ch.ready;

  assign a_s    = $signed(a_i);
  assign b_s    = $signed(b_i);
  assign prod_d = term_i.mismatch ? '0 : PROD_W'(a_s * b_s);
  assign acc_d  = (tag2_q.first ? '0 : acc_q) + ACC_W'(prod_q);

  // Only the last term of an entry moves on to the result stage.
  always_comb begin
    tag3_d       = tag2_q;
    tag3_d.valid = tag2_q.valid && tag2_q.last_term;
  end

  // Round half up, then saturate when the bits above the result are not all
  // copies of its sign.
  always_comb begin
    rnd     = acc_q + ROUND_HALF;
    rnd_top = rnd[ACC_W-1:TopLo];
    if ((&rnd_top) || !(|rnd_top)) begin
      sat = rnd[TopLo:FRAC_W];
    end else if (rnd[ACC_W-1]) begin
      sat = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q      <= '0;
      tag3_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (!hold_o) begin
      tag2_q      <= term_i;
      tag3_q      <= tag3_d;
      out_valid_q <= tag3_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold_o) begin
      prod_q <= prod_d;
      if (tag2_q.valid) begin
        acc_q <= acc_d;
      end
      if (tag3_q.valid) begin
        out_row_q    <= tag3_q.row;
        out_col_q    <= tag3_q.col;
        out_value_q  <= sat;
        out_status_q <= tag3_q.mismatch;
        out_last_q   <= tag3_q.last_entry;
      end
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.out_row       = out_row_q;
  assign out_ch.out_col       = out_col_q;
  assign out_ch.product_value = out_value_q;
  assign out_ch.status        = out_status_q;
  assign out_ch.last          = out_last_q;

endmodule

@@ rtl/matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply: fixed-point matrix multiply
// Loads A and B entry by entry and streams the Q16.16 product row-major.
//
//   Channel  Dir  Handshake            Content
//   in_ch    in   valid/ready          command, row_index, col_index, element
//   out_ch   out  valid/ready          out_row, out_col, product, status, last
//   cfg      in   cfg_we_i, no wait    rows_a, cols_a, rows_b, cols_b
//
// The execute side writes a load into its store as it dequeues it. A compute
// issues its n*p*m multiply-accumulates to the shared MAC; after an entry's
// last term, its result passes the product, accumulator and output registers.
// A size mismatch sends a single status result down the same path.
// Reset clears control state only; the stores hold nothing until loaded.
// A four-entry queue lets commands be taken while the MAC works; a stall on
// the result channel freezes the execute side and the MAC.
// ----------------------------------------------------------------------------
module matrix_multiply #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mm_in_if.sink                         in_ch,
  mm_out_if.source                      out_ch,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [mm_pkg::DIM_W-1:0]      cfg_data_i
);
  import mm_pkg::*;

  logic [DIM_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  dims_t            dims;

  logic              q_push, q_pop, q_full, q_empty;
  q_item_t           q_item, q_head;
  term_t             term;
  logic [DATA_W-1:0] a_data, b_data;
  logic              hold;

  // Out-of-range sizes act as the nearest legal size.
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] e;
    if (r == '0) begin
      e = DIM_W'(1);
    end else if (32'(r) > MAX_DIM) begin
      e = DIM_W'(MAX_DIM);
    end else begin
      e = r;
    end
    return IDX_W'(e - DIM_W'(1));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= ROWS_A_RESET;
      cols_a_q <= COLS_A_RESET;
      rows_b_q <= ROWS_B_RESET;
      cols_b_q <= COLS_B_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROWS_A: rows_a_q <= cfg_data_i;
        CFG_COLS_A: cols_a_q <= cfg_data_i;
        CFG_ROWS_B: rows_b_q <= cfg_data_i;
        CFG_COLS_B: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    dims.rows_last  = dim_last(rows_a_q);
    dims.inner_last = dim_last(cols_a_q);
    dims.cols_last  = dim_last(cols_b_q);
    dims.mismatch   = (dim_last(cols_a_q) != dim_last(rows_b_q));
  end

  mm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .in_ch    (in_ch),
    .dims_i   (dims),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_item)
  );

  mm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mm_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .dims_i    (dims),
    .hold_i    (hold),
    .term_o    (term),
    .a_data_o  (a_data),
    .b_data_o  (b_data)
  );

  mm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .term_i (term),
    .a_i    (a_data),
    .b_i    (b_data),
    .hold_o (hold),
    .out_ch (out_ch)
  );

endmodule

@@ rtl/mm_checker.sv @@
// ----------------------------------------------------------------------------
// mm_checker: result channel checks
// Watches the result port: stall behavior, status result shape and the
// row-major order of product entries within one run.
// ----------------------------------------------------------------------------
module mm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_row_i,
  input logic [2:0]  out_col_i,
  input logic [31:0] out_value_i,
  input logic        out_status_i,
  input logic        out_last_i
);

  logic       xfer;
  logic       pend_q;
  logic [2:0] prev_row_q, prev_col_q;

  assign xfer = out_valid_i && out_ready_i;

  // Tracks whether the next transfer continues a run of product entries.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      prev_row_q <= '0;
      prev_col_q <= '0;
    end else if (xfer) begin
      pend_q     <= !out_last_i;
      prev_row_q <= out_row_i;
      prev_col_q <= out_col_i;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_row_i) &&
      $stable(out_col_i) && $stable(out_value_i) && $stable(out_status_i) &&
      $stable(out_last_i))
    else $error("result changed while stalled");

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i |-> out_last_i && (out_row_i == 3'd0) &&
      (out_col_i == 3'd0) && (out_value_i == 32'd0))
    else $error("malformed size mismatch result");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !pend_q && !out_status_i |-> (out_row_i == 3'd0) && (out_col_i == 3'd0))
    else $error("product run does not start at the first entry");

  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && pend_q |-> !out_status_i &&
      (((out_row_i == prev_row_q) && (out_col_i == 3'(prev_col_q + 3'd1))) ||
       ((out_row_i == 3'(prev_row_q + 3'd1)) && (out_col_i == 3'd0))))
    else $error("product entries out of row-major order");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_row_i    (out_ch.out_row),
  .out_col_i    (out_ch.out_col),
  .out_value_i  (out_ch.product_value),
  .out_status_i (out_ch.status),
  .out_last_i   (out_ch.last)
);

@@ verif/mm_product_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_product_check: result checker for the matrix multiply block
// Watches the command, result and configuration ports, keeps its own copy of
// both stores and the sizes, predicts every product entry in Q16.16 and
// compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module mm_product_check (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  mm_in_if                         cmd_mon,
  mm_out_if                        res_mon,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [mm_pkg::DIM_W-1:0] cfg_data_i,
  output int unsigned              error_count_o,
  output int unsigned              pending_o
);
  import mm_pkg::*;

  localparam int unsigned MAX_DIM = 8;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              status;
    logic              last;
  } product_entry_t;

  logic [DATA_W-1:0] a_store [MAX_DIM*MAX_DIM];
  logic [DATA_W-1:0] b_store [MAX_DIM*MAX_DIM];
  logic [DIM_W-1:0]  rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  product_entry_t    product_q [$];

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] dim);
    if (dim == '0) return 1;
    if (dim > MAX_DIM) return MAX_DIM;
    return int'(dim);
  endfunction

  // Products are exact in Q32.32 and summed exactly; one rounding to nearest
  // (ties upward) and a saturation to 32 bits follow.
  function automatic logic [DATA_W-1:0] entry_value(input int unsigned row, col, inner);
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  sum;
    logic signed [ACC_W-1:0]  rounded;
    sum = '0;
    for (int unsigned t = 0; t < inner; t++) begin
      prod = $signed(a_store[row*MAX_DIM+t]) * $signed(b_store[t*MAX_DIM+col]);
      sum  = sum + prod;
    end
    rounded = (sum + 32'sd32768) >>> FRAC_W;
    if (rounded > SAT_HI) return 32'h7FFF_FFFF;
    if (rounded < SAT_LO) return 32'h8000_0000;
    return rounded[DATA_W-1:0];
  endfunction

  task automatic predict_product();
    int unsigned    n, m, inner_b, p;
    product_entry_t entry;
    n       = eff_dim(rows_a_q);
    m       = eff_dim(cols_a_q);
    inner_b = eff_dim(rows_b_q);
    p       = eff_dim(cols_b_q);
    if (m != inner_b) begin
      entry        = '0;
      entry.status = 1'b1;
      entry.last   = 1'b1;
      product_q.push_back(entry);
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        for (int unsigned j = 0; j < p; j++) begin
          entry.row    = IDX_W'(i);
          entry.col    = IDX_W'(j);
          entry.value  = entry_value(i, j, m);
          entry.status = 1'b0;
          entry.last   = (i == n - 1) && (j == p - 1);
          product_q.push_back(entry);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                             input logic [DATA_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_val, act_val);
      error_count_o++;
    end
  endtask

  task automatic check_result();
    product_entry_t entry;
    if (product_q.size() == 0) begin
      $error("result transfer with no product entry expected (row %0d col %0d)",
             res_mon.out_row, res_mon.out_col);
      error_count_o++;
    end else begin
      entry = product_q.pop_front();
      check_field("out_row", DATA_W'(entry.row), DATA_W'(res_mon.out_row));
      check_field("out_col", DATA_W'(entry.col), DATA_W'(res_mon.out_col));
      check_field("product_value", entry.value, res_mon.product_value);
      check_field("status", DATA_W'(entry.status), DATA_W'(res_mon.status));
      check_field("last", DATA_W'(entry.last), DATA_W'(res_mon.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q      = ROWS_A_RESET;
      cols_a_q      = COLS_A_RESET;
      rows_b_q      = ROWS_B_RESET;
      cols_b_q      = COLS_B_RESET;
      product_q.delete();
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        check_result();
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ROWS_A: rows_a_q = cfg_data_i;
          CFG_COLS_A: cols_a_q = cfg_data_i;
          CFG_ROWS_B: rows_b_q = cfg_data_i;
          CFG_COLS_B: cols_b_q = cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        case (cmd_mon.command)
          CMD_LOAD_A:  a_store[{cmd_mon.row_index, cmd_mon.col_index}] = cmd_mon.element_value;
          CMD_LOAD_B:  b_store[{cmd_mon.row_index, cmd_mon.col_index}] = cmd_mon.element_value;
          CMD_COMPUTE: predict_product();
          default: ;
        endcase
      end
      pending_o = product_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the matrix multiply block
// Loads operands and issues products under several matrix sizes, including
// size mismatches, rounding ties and saturation, with random gaps on the
// command side and random stalls on the result side. Checking is done by
// mm_product_check; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import mm_pkg::*;

  localparam int unsigned MAX_DIM         = 8;
  localparam time         CLK_PERIOD      = 12ns;
  localparam int unsigned RESET_CYCLES    = 9;
  localparam int unsigned RANDOM_ITEMS    = 160;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam logic [1:0]  CMD_UNUSED      = 2'd3;

  localparam logic [DATA_W-1:0] CORNER_VALUES [8] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_index_i;
  logic [DIM_W-1:0] cfg_data_i;

  mm_in_if  cmd_ch ();
  mm_out_if res_ch ();

  int unsigned error_count;
  int unsigned pending;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned item_count;
  int unsigned dim_n, dim_m, dim_mb, dim_p;
  bit          hold_req;
  bit          hold_done;
  bit          written_a [MAX_DIM*MAX_DIM];
  bit          written_b [MAX_DIM*MAX_DIM];

  matrix_multiply #(
    .MAX_DIM(MAX_DIM)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (cmd_ch),
    .out_ch     (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  mm_product_check i_product_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_mon      (cmd_ch),
    .res_mon      (res_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
  end

  // Result side: random stalls, plus one long hold-off so the command queue
  // fills up and the block stops taking commands.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #12_000_000;
    $display("matrix_multiply regression: fail");
    $finish;
  end

  function automatic logic [DATA_W-1:0] rand_element();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 25) return $urandom;
    if (sel < 65) return DATA_W'(int'($urandom_range(1 << 20)) - (1 << 19));
    if (sel < 80) return CORNER_VALUES[$urandom_range(7)];
    // Mostly fractional values, so rounding is exercised.
    return DATA_W'(int'($urandom_range(1 << 17)) - (1 << 16));
  endfunction

  function automatic int unsigned rand_dim();
    if ($urandom_range(99) < 10) return MAX_DIM;
    return $urandom_range(1, 4);
  endfunction

  // A size register of zero acts as one, and anything above the maximum acts
  // as the maximum, so those encodings are mixed in.
  function automatic logic [DIM_W-1:0] encode_dim(input int unsigned dim);
    if (dim == 1 && $urandom_range(3) == 0) return '0;
    if (dim == MAX_DIM && $urandom_range(1) == 0) return DIM_W'($urandom_range(MAX_DIM + 1, 15));
    return DIM_W'(dim);
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [IDX_W-1:0] row, col,
                           input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.command       <= cmd;
    cmd_ch.row_index     <= row;
    cmd_ch.col_index     <= col;
    cmd_ch.element_value <= value;
    do @(posedge clk_i); while (!cmd_ch.ready);
    if (cmd == CMD_LOAD_A) written_a[{row, col}] = 1'b1;
    if (cmd == CMD_LOAD_B) written_b[{row, col}] = 1'b1;
    if (cmd != CMD_UNUSED) item_count++;
  endtask

  task automatic write_dims(input logic [DIM_W-1:0] ra, ca, rb, cb);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROWS_A;
    cfg_data_i  <= ra;
    @(negedge clk_i);
    cfg_index_i <= CFG_COLS_A;
    cfg_data_i  <= ca;
    @(negedge clk_i);
    cfg_index_i <= CFG_ROWS_B;
    cfg_data_i  <= rb;
    @(negedge clk_i);
    cfg_index_i <= CFG_COLS_B;
    cfg_data_i  <= cb;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Loads with no result may still sit in the queue after the last product
  // entry, so drain also waits SETTLE_CYCLES before the block counts as idle.
  task automatic drain();
    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Random loads and the odd unused command, then every operand entry the
  // product reads that was never written, then the compute itself.
  task automatic run_product(input int unsigned extra_loads);
    repeat (extra_loads) begin
      if ($urandom_range(19) == 0) begin
        send_item(CMD_UNUSED, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)), $urandom);
      end else begin
        send_item($urandom_range(1) ? CMD_LOAD_B : CMD_LOAD_A, IDX_W'($urandom_range(7)),
                  IDX_W'($urandom_range(7)), rand_element());
      end
    end
    if (dim_m == dim_mb) begin
      for (int unsigned i = 0; i < dim_n; i++) begin
        for (int unsigned t = 0; t < dim_m; t++) begin
          if (!written_a[i*MAX_DIM+t]) begin
            send_item(CMD_LOAD_A, IDX_W'(i), IDX_W'(t), rand_element());
          end
        end
      end
      for (int unsigned t = 0; t < dim_m; t++) begin
        for (int unsigned j = 0; j < dim_p; j++) begin
          if (!written_b[t*MAX_DIM+j]) begin
            send_item(CMD_LOAD_B, IDX_W'(t), IDX_W'(j), rand_element());
          end
        end
      end
    end
    send_item(CMD_COMPUTE, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)), $urandom);
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned rounds;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_ROWS_A;
    cfg_data_i           = '0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.command       = CMD_LOAD_A;
    cmd_ch.row_index     = '0;
    cmd_ch.col_index     = '0;
    cmd_ch.element_value = '0;
    gap_pct              = 0;
    stall_pct            = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset sizes, 2x3 by 3x2: both saturation directions, a half-LSB term,
    // the unused command and loads outside the configured size.
    send_item(CMD_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_item(CMD_LOAD_A, 3'd0, 3'd1, 32'h8000_0000);
    send_item(CMD_LOAD_A, 3'd0, 3'd2, 32'h0000_8000);
    send_item(CMD_LOAD_A, 3'd1, 3'd0, 32'hFFFF_FFFF);
    send_item(CMD_LOAD_A, 3'd1, 3'd1, 32'h0001_0000);
    send_item(CMD_LOAD_A, 3'd1, 3'd2, 32'h0000_0000);
    send_item(CMD_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_item(CMD_LOAD_B, 3'd0, 3'd1, 32'h0000_0001);
    send_item(CMD_LOAD_B, 3'd1, 3'd0, 32'h8000_0000);
    send_item(CMD_LOAD_B, 3'd1, 3'd1, 32'hFFFF_8000);
    send_item(CMD_LOAD_B, 3'd2, 3'd0, 32'h0000_0001);
    send_item(CMD_LOAD_B, 3'd2, 3'd1, 32'h0001_8000);
    send_item(CMD_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_item(CMD_LOAD_A, 3'd7, 3'd7, 32'h5555_5555);
    send_item(CMD_LOAD_B, 3'd7, 3'd7, 32'hAAAA_AAAA);
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);
    drain();

    // 1x1 products that land exactly halfway, positive and negative.
    write_dims(4'd1, 4'd1, 4'd0, 4'd1);
    send_item(CMD_LOAD_A, 3'd0, 3'd0, 32'h0000_8000);
    send_item(CMD_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
    send_item(CMD_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_item(CMD_LOAD_A, 3'd0, 3'd0, 32'hFFFF_8000);
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);
    drain();

    write_dims(4'd2, 4'd3, 4'd2, 4'd2);
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);
    drain();

    item_count = 0;
    phase_no   = 0;
    while (item_count < RANDOM_ITEMS) begin
      case (phase_no % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 48;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 48;
        end
        default: begin
          gap_pct   = 7;
          stall_pct = 7;
        end
      endcase
      if (phase_no == 0) begin
        dim_n  = MAX_DIM;
        dim_m  = 1;
        dim_mb = 1;
        dim_p  = MAX_DIM;
        write_dims(4'd8, 4'd1, 4'd1, 4'd15);
      end else if (phase_no == 1) begin
        dim_n  = 1;
        dim_m  = MAX_DIM;
        dim_mb = MAX_DIM;
        dim_p  = 1;
        write_dims(4'd0, 4'd15, 4'd8, 4'd0);
      end else begin
        dim_n  = rand_dim();
        dim_m  = rand_dim();
        dim_p  = rand_dim();
        dim_mb = ($urandom_range(99) < 15) ? dim_m % MAX_DIM + 1 : dim_m;
        write_dims(encode_dim(dim_n), encode_dim(dim_m), encode_dim(dim_mb),
                   encode_dim(dim_p));
      end
      rounds = (phase_no == 0) ? 3 : $urandom_range(1, 3);
      for (int unsigned k = 0; k < rounds; k++) begin
        // In the first phase the result side holds off while commands keep
        // coming, so the command queue fills and command transfers stall.
        if (phase_no == 0 && k == 0) hold_req = 1'b1;
        run_product((phase_no == 0) ? 6 : $urandom_range(0, 6));
      end
      drain();
      phase_no++;
    end

    if (error_count == 0) begin
      $display("matrix_multiply regression: pass");
    end else begin
      $display("matrix_multiply regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mm_pkg.sv
rtl/mm_in_if.sv
rtl/mm_out_if.sv
rtl/mm_front.sv
rtl/mm_fifo.sv
rtl/mm_back.sv
rtl/mm_mac.sv
rtl/matrix_multiply.sv
rtl/mm_checker.sv
verif/mm_product_check.sv
verif/tb.sv
